// ----- design/rbsi_pkg.sv -----
package rbsi_pkg;

  localparam int DataWidth = 32;
  localparam int FracBitsDefault = 16;
  localparam int NumAxes = 3;

  typedef logic signed [DataWidth-1:0] fix_t;

  typedef struct packed {
    fix_t origin_x;
    fix_t origin_y;
    fix_t origin_z;
    fix_t dir_x;
    fix_t dir_y;
    fix_t dir_z;
    fix_t box_min_x;
    fix_t box_min_y;
    fix_t box_min_z;
    fix_t box_max_x;
    fix_t box_max_y;
    fix_t box_max_z;
  } ray_box_t;

  typedef struct packed {
    logic hit;
    fix_t distance;
  } hit_result_t;

  localparam fix_t FixMax = 32'sh7FFF_FFFF;
  localparam fix_t FixMin = 32'sh8000_0000;

  // Applies a sign to a 64-bit magnitude and saturates to 32 bits.
  function automatic fix_t sign_sat(input logic [63:0] mag, input logic neg);
    fix_t r;
    r = '0;
    if (neg) begin
      if (mag >= 64'h8000_0000) r = FixMin;
      else r = fix_t'(-mag[31:0]);
    end else begin
      if (mag > 64'h7FFF_FFFF) r = FixMax;
      else r = fix_t'(mag[31:0]);
    end
    return r;
  endfunction

endpackage

// ----- design/rbsi_if.sv -----
interface rbsi_ray_if;
  import rbsi_pkg::*;
  logic valid;
  logic ready;
  fix_t origin_x;
  fix_t origin_y;
  fix_t origin_z;
  fix_t dir_x;
  fix_t dir_y;
  fix_t dir_z;
  fix_t box_min_x;
  fix_t box_min_y;
  fix_t box_min_z;
  fix_t box_max_x;
  fix_t box_max_y;
  fix_t box_max_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                output ready);
endinterface

interface rbsi_hit_if;
  import rbsi_pkg::*;
  logic valid;
  logic ready;
  logic hit;
  fix_t distance;
  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

// ----- design/ray_box_slab_intersect.sv -----
// Channel | Dir | Payload
// ray     | in  | origin, dir, box_min, box_max (x, y, z), signed fixed point
// res     | out | hit, distance
// One beat per cycle while the output is not stalled; a result beat passes, after its ray beat
// is accepted, through the 2*FracBits + 3 stage divider chain, stages A to C, tn_q/tf_q and res.
// The pipeline advances as one piece whenever the output register is free or taken.
// Synchronous reset clears the valid bits only; a stall holds every stage.
module ray_box_slab_intersect
  import rbsi_pkg::*;
#(
  parameter int FracBits = FracBitsDefault
) (
  input  logic clk,
  input  logic rst,
  rbsi_ray_if.sink   ray,
  rbsi_hit_if.source res
);
  localparam int DivLat = 2 * FracBits + 3;
  localparam int Lat = DivLat + 4;

  logic en;
  logic [Lat-1:0] vld;
  ray_box_t dly [DivLat];
  fix_t inv [NumAxes];
  fix_t orgs [NumAxes], mins [NumAxes], maxs [NumAxes], dirs [NumAxes];

  assign en = !res.valid || res.ready;
  assign ray.ready = en;

  assign dirs[0] = ray.dir_x;
  assign dirs[1] = ray.dir_y;
  assign dirs[2] = ray.dir_z;

  for (genvar a = 0; a < NumAxes; a++) begin : g_div
    rbsi_recip #(.FracBits(FracBits)) u_recip (
      .clk(clk), .en(en), .d(dirs[a]), .inv(inv[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], ray.valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= '{ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y,
                  ray.dir_z, ray.box_min_x, ray.box_min_y, ray.box_min_z,
                  ray.box_max_x, ray.box_max_y, ray.box_max_z};
      for (int i = 1; i < DivLat; i++) dly[i] <= dly[i-1];
    end
  end

  assign orgs[0] = dly[DivLat-1].origin_x;
  assign orgs[1] = dly[DivLat-1].origin_y;
  assign orgs[2] = dly[DivLat-1].origin_z;
  assign mins[0] = dly[DivLat-1].box_min_x;
  assign mins[1] = dly[DivLat-1].box_min_y;
  assign mins[2] = dly[DivLat-1].box_min_z;
  assign maxs[0] = dly[DivLat-1].box_max_x;
  assign maxs[1] = dly[DivLat-1].box_max_y;
  assign maxs[2] = dly[DivLat-1].box_max_z;

  // Stage A: offsets and magnitudes. Stage B: products. Stage C: saturate.
  logic [32:0] om0 [NumAxes], om1 [NumAxes];
  logic [31:0] im [NumAxes];
  logic        s0 [NumAxes], s1 [NumAxes];
  logic [64:0] p0 [NumAxes], p1 [NumAxes];
  logic        sb0 [NumAxes], sb1 [NumAxes];
  fix_t        t0 [NumAxes], t1 [NumAxes];
  fix_t        lo [NumAxes], hi [NumAxes];
  fix_t        tnear, tfar;
  fix_t        tn_q, tf_q;

  for (genvar a = 0; a < NumAxes; a++) begin : g_slab
    logic signed [32:0] f0, f1;
    always_comb begin
      f0 = 33'(mins[a]) - 33'(orgs[a]);
      f1 = 33'(maxs[a]) - 33'(orgs[a]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        om0[a] <= f0[32] ? 33'(-f0) : 33'(f0);
        om1[a] <= f1[32] ? 33'(-f1) : 33'(f1);
        im[a]  <= inv[a][31] ? 32'(-inv[a]) : 32'(inv[a]);
        s0[a]  <= f0[32] ^ inv[a][31];
        s1[a]  <= f1[32] ^ inv[a][31];
        p0[a]  <= 65'(om0[a]) * 65'(im[a]);
        p1[a]  <= 65'(om1[a]) * 65'(im[a]);
        sb0[a] <= s0[a];
        sb1[a] <= s1[a];
        t0[a]  <= sign_sat(64'(p0[a] >> FracBits), sb0[a]);
        t1[a]  <= sign_sat(64'(p1[a] >> FracBits), sb1[a]);
      end
    end
    assign lo[a] = (t0[a] < t1[a]) ? t0[a] : t1[a];
    assign hi[a] = (t0[a] < t1[a]) ? t1[a] : t0[a];
  end

  always_comb begin
    tnear = FixMin;
    tfar  = FixMax;
    for (int a = 0; a < NumAxes; a++) begin
      if (lo[a] > tnear) tnear = lo[a];
      if (hi[a] < tfar) tfar = hi[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tn_q <= tnear;
      tf_q <= tfar;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= vld[Lat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tn_q <= tf_q && !tf_q[31]) begin
        res.hit <= 1'b1;
        res.distance <= tn_q[31] ? tf_q : tn_q;
      end else begin
        res.hit <= 1'b0;
        res.distance <= -(fix_t'(1) <<< FracBits);
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.distance))
    else $error("result changed under stall");
  a_miss_dist: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.hit |-> res.distance == -(fix_t'(1) <<< FracBits))
    else $error("miss distance wrong");
  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.hit |-> !res.distance[31])
    else $error("negative hit distance");
endmodule

// ----- design/rbsi_recip.sv -----
// Pipelined restoring divider: 2^(2F) / |d|, one quotient bit per stage.
module rbsi_recip
  import rbsi_pkg::*;
#(
  parameter int FracBits = FracBitsDefault
) (
  input  logic clk,
  input  logic en,
  input  fix_t d,
  output fix_t inv
);
  localparam int QBits = 2 * FracBits + 1;
  localparam int RBits = 34;

  logic [RBits-1:0] rem [QBits+1];
  logic [QBits-1:0] quo [QBits+1];
  logic [31:0]      dm  [QBits+1];
  logic             neg [QBits+1];
  logic             zer [QBits+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      quo[0] <= '0;
      dm[0]  <= d[31] ? 32'(-d) : 32'(d);
      neg[0] <= d[31];
      zer[0] <= (d == '0);
    end
  end

  for (genvar i = 0; i < QBits; i++) begin : g_step
    logic [RBits-1:0] trial;
    logic             nb;
    always_comb begin
      nb    = (i == 0);
      trial = {rem[i][RBits-2:0], nb};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {2'b00, dm[i]}) begin
          rem[i+1] <= trial - {2'b00, dm[i]};
          quo[i+1] <= {quo[i][QBits-2:0], 1'b1};
        end else begin
          rem[i+1] <= trial;
          quo[i+1] <= {quo[i][QBits-2:0], 1'b0};
        end
        dm[i+1]  <= dm[i];
        neg[i+1] <= neg[i];
        zer[i+1] <= zer[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv <= zer[QBits] ? FixMax : sign_sat(64'(quo[QBits]), neg[QBits]);
    end
  end
endmodule
